// ===== sv/dha_pkg.sv =====
// ----------------------------------------------------------------------------
// dha_pkg
// Shared constants of the dihedral angle core: multiplier digit size, queue
// size, CORDIC widths and the arctangent table.
// ----------------------------------------------------------------------------
package dha_pkg;
  localparam int MUL_CHUNK = 16;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = 2;
  localparam int Q_CW = 3;
  localparam int TAB_FRAC = 30;
  localparam int TAKE_W = 30;
  localparam int CORDIC_XW = 34;
  localparam int CORDIC_ZW = 33;
  localparam int THETA_W = 35;
  localparam logic signed [THETA_W-1:0] PI30 = 35'sd3373259426;
  localparam logic [29:0] ATAN_TAB [30] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001
  };
endpackage

// ===== sv/dha_if.sv =====
// ----------------------------------------------------------------------------
// dha_in_if / dha_res_if
// Valid/ready channels of the dihedral angle core: four points in, one
// angle out.
// ----------------------------------------------------------------------------
interface dha_in_if #(parameter int COORD_WIDTH = 24);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] p0_x, p0_y, p0_z;
  logic signed [COORD_WIDTH-1:0] p1_x, p1_y, p1_z;
  logic signed [COORD_WIDTH-1:0] p2_x, p2_y, p2_z;
  logic signed [COORD_WIDTH-1:0] p3_x, p3_y, p3_z;
  modport source(output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
                 p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, input ready);
  modport sink(input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
               p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, output ready);
endinterface

interface dha_res_if #(parameter int ANGLE_FRAC_BITS = 15);
  logic valid;
  logic ready;
  logic signed [ANGLE_FRAC_BITS+2:0] angle;
  logic degenerate;
  modport source(output valid, angle, degenerate, input ready);
  modport sink(input valid, angle, degenerate, output ready);
endinterface

// ===== sv/dihedral_angle_core.sv =====
// ----------------------------------------------------------------------------
// dihedral_angle_core
// Dihedral angle of four points, atan2 of the sine and cosine terms.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat of four points is taken every cycle unless the
// front is stalled, and one angle beat leaves per input beat, in order. The
// stages are the vector math in the front plus one per 16-bit digit of the
// normal products, one per result bit of the bond length square root
// (COORD_WIDTH+18), one per 16-bit digit of the sine product, the
// normalization and rounding stages and one per CORDIC step, with the queue
// between front and back. Backpressure on the result channel holds the back
// end; the queue then lets the front keep taking beats until it fills.
module dihedral_angle_core #(
  parameter int COORD_WIDTH = 24,
  parameter int ANGLE_FRAC_BITS = 15,
  parameter int CORDIC_STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  dha_in_if.sink    pts,
  dha_res_if.source res
);
  localparam int DW = 9 * COORD_WIDTH + 18;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [DW-1:0] f_data, b_data;

  dha_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .pts(pts),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  dha_fifo #(.DW(DW)) u_fifo (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  dha_back #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .res(res)
  );
endmodule

// ===== sv/dha_mul.sv =====
// ----------------------------------------------------------------------------
// dha_mul
// Pipelined signed multiplier, one digit of b per stage.
// ----------------------------------------------------------------------------
module dha_mul #(
  parameter int AW = 8,
  parameter int BWID = 8
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [AW-1:0]        a,
  input  logic signed [BWID-1:0]      b,
  output logic signed [AW+BWID-1:0]   p
);
  localparam int CH = dha_pkg::MUL_CHUNK;
  localparam int NC = (BWID + CH - 1) / CH;
  localparam int EW = NC * CH;
  localparam int PWD = AW + BWID;

  logic signed [AW-1:0]  a_q   [NC];
  logic signed [EW-1:0]  b_q   [NC];
  logic signed [PWD-1:0] acc_q [NC];
  logic signed [EW-1:0]  b_ext;

  assign b_ext = EW'(b);

  for (genvar k = 0; k < NC; k++) begin : g_st
    logic signed [AW-1:0]   a_i;
    logic signed [EW-1:0]   b_i;
    logic signed [PWD-1:0]  acc_i;
    logic signed [CH:0]     dig;
    logic signed [AW+CH:0]  pp;
    if (k == 0) begin : g_first
      assign a_i = a;
      assign b_i = b_ext;
      assign acc_i = '0;
    end else begin : g_next
      assign a_i = a_q[k-1];
      assign b_i = b_q[k-1];
      assign acc_i = acc_q[k-1];
    end
    if (k == NC - 1) begin : g_top
      assign dig = {b_i[k*CH+CH-1], b_i[k*CH +: CH]};
    end else begin : g_low
      assign dig = {1'b0, b_i[k*CH +: CH]};
    end
    assign pp = a_i * dig;
    always_ff @(posedge clk) begin
      if (en) begin
        a_q[k] <= a_i;
        b_q[k] <= b_i;
        acc_q[k] <= acc_i + (PWD'(pp) <<< (CH * k));
      end
    end
  end

  assign p = acc_q[NC-1];
endmodule

// ===== sv/dha_front.sv =====
// ----------------------------------------------------------------------------
// dha_front
// Bond vectors, plane normals, squared middle bond and the two dot products.
// ----------------------------------------------------------------------------
module dha_front #(
  parameter int COORD_WIDTH = 24
) (
  input  logic          clk,
  input  logic          rst,
  dha_in_if.sink        pts,
  output logic          q_valid,
  input  logic          q_ready,
  output logic [9*COORD_WIDTH+17:0] q_data
);
  localparam int BW = COORD_WIDTH + 1;
  localparam int NW = 2 * BW + 1;
  localparam int D1W = NW + BW + 2;
  localparam int D2W = 2 * NW + 2;
  localparam int QW = 2 * BW + 2;
  localparam int NC = (NW + dha_pkg::MUL_CHUNK - 1) / dha_pkg::MUL_CHUNK;
  localparam int FL = 4 + NC;

  logic [FL-1:0] v;
  logic en;
  logic signed [BW-1:0]     b0 [3], b1 [3], b2 [3], b2s [3];
  logic signed [2*BW-1:0]   pl [6], pr [6], sq [3];
  logic signed [NW-1:0]     nl [3], nr [3], b2e [3];
  logic [QW-1:0]            nsq, nsq_o;
  logic [QW-1:0]            nsq_d [NC];
  logic signed [2*NW-1:0]   m1 [3], m2 [3];
  logic signed [D1W-1:0]    d1;
  logic signed [D2W-1:0]    d2;

  assign en = !v[FL-1] || q_ready;
  assign pts.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[FL-2:0], pts.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0[0] <= BW'(pts.p1_x) - BW'(pts.p0_x);
      b0[1] <= BW'(pts.p1_y) - BW'(pts.p0_y);
      b0[2] <= BW'(pts.p1_z) - BW'(pts.p0_z);
      b1[0] <= BW'(pts.p2_x) - BW'(pts.p1_x);
      b1[1] <= BW'(pts.p2_y) - BW'(pts.p1_y);
      b1[2] <= BW'(pts.p2_z) - BW'(pts.p1_z);
      b2[0] <= BW'(pts.p3_x) - BW'(pts.p2_x);
      b2[1] <= BW'(pts.p3_y) - BW'(pts.p2_y);
      b2[2] <= BW'(pts.p3_z) - BW'(pts.p2_z);

      pl[0] <= b0[1] * b1[2];
      pl[1] <= b0[2] * b1[1];
      pl[2] <= b0[2] * b1[0];
      pl[3] <= b0[0] * b1[2];
      pl[4] <= b0[0] * b1[1];
      pl[5] <= b0[1] * b1[0];
      pr[0] <= b1[1] * b2[2];
      pr[1] <= b1[2] * b2[1];
      pr[2] <= b1[2] * b2[0];
      pr[3] <= b1[0] * b2[2];
      pr[4] <= b1[0] * b2[1];
      pr[5] <= b1[1] * b2[0];
      sq[0] <= b1[0] * b1[0];
      sq[1] <= b1[1] * b1[1];
      sq[2] <= b1[2] * b1[2];
      b2s <= b2;

      for (int j = 0; j < 3; j++) begin
        nl[j] <= NW'(pl[2*j]) - NW'(pl[2*j+1]);
        nr[j] <= NW'(pr[2*j]) - NW'(pr[2*j+1]);
        b2e[j] <= NW'(b2s[j]);
      end
      nsq <= QW'($unsigned(sq[0])) + QW'($unsigned(sq[1])) + QW'($unsigned(sq[2]));

      nsq_d[0] <= nsq;
      for (int k = 1; k < NC; k++) nsq_d[k] <= nsq_d[k-1];

      d1 <= D1W'(m1[0]) + D1W'(m1[1]) + D1W'(m1[2]);
      d2 <= D2W'(m2[0]) + D2W'(m2[1]) + D2W'(m2[2]);
      nsq_o <= nsq_d[NC-1];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_dot
    dha_mul #(.AW(NW), .BWID(NW)) u_mb (
      .clk(clk), .en(en), .a(nl[j]), .b(b2e[j]), .p(m1[j])
    );
    dha_mul #(.AW(NW), .BWID(NW)) u_mn (
      .clk(clk), .en(en), .a(nl[j]), .b(nr[j]), .p(m2[j])
    );
  end

  assign q_valid = v[FL-1];
  assign q_data = {nsq_o, d1, d2};
endmodule

// ===== sv/dha_fifo.sv =====
// ----------------------------------------------------------------------------
// dha_fifo
// Short queue between the vector front end and the angle back end.
// ----------------------------------------------------------------------------
module dha_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_data
);
  logic [DW-1:0] mem [dha_pkg::Q_DEPTH];
  logic [dha_pkg::Q_AW-1:0] wp, rp;
  logic [dha_pkg::Q_CW-1:0] cnt;
  logic push, pop;

  assign in_ready = cnt != dha_pkg::Q_CW'(dha_pkg::Q_DEPTH);
  assign out_valid = cnt != '0;
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  assign out_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + dha_pkg::Q_CW'(push) - dha_pkg::Q_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end
endmodule

// ===== sv/dha_back.sv =====
// ----------------------------------------------------------------------------
// dha_back
// Bond length square root, sine and cosine terms, normalization, CORDIC
// vectoring and rounding to the output angle.
// ----------------------------------------------------------------------------
module dha_back #(
  parameter int COORD_WIDTH = 24,
  parameter int ANGLE_FRAC_BITS = 15,
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [9*COORD_WIDTH+17:0] q_data,
  dha_res_if.source     res
);
  localparam int CH = dha_pkg::MUL_CHUNK;
  localparam int BW = COORD_WIDTH + 1;
  localparam int NW = 2 * BW + 1;
  localparam int D1W = NW + BW + 2;
  localparam int D2W = 2 * NW + 2;
  localparam int QW = 2 * BW + 2;
  localparam int TW = QW + 32;
  localparam int RW = TW / 2;
  localparam int NC2 = (D1W + CH - 1) / CH;
  localparam int SW = RW + D1W;
  localparam int CW2 = D2W + 16;
  localparam int PW = (SW > CW2) ? SW : CW2;
  localparam int NG = (PW + CH - 1) / CH;
  localparam int TPW = $clog2(NG * CH);
  localparam int AW = ANGLE_FRAC_BITS + 3;
  localparam int SH = dha_pkg::TAB_FRAC - ANGLE_FRAC_BITS;
  localparam int XW = dha_pkg::CORDIC_XW;
  localparam int ZW = dha_pkg::CORDIC_ZW;
  localparam int HW = dha_pkg::THETA_W;
  localparam int TK = dha_pkg::TAKE_W;
  localparam int BL = RW + NC2 + 4 + CORDIC_STEPS + 1;
  localparam logic signed [HW-1:0] HALF = HW'(1) << (SH - 1);
  localparam logic signed [HW-1:0] PIQ = (dha_pkg::PI30 + HALF) >>> SH;

  logic [BL-1:0] v;
  logic en;
  logic [QW-1:0] nsq_i;
  logic signed [D1W-1:0] d1_i;
  logic signed [D2W-1:0] d2_i;

  assign nsq_i = q_data[QW+D1W+D2W-1 -: QW];
  assign d1_i = q_data[D1W+D2W-1 -: D1W];
  assign d2_i = q_data[D2W-1:0];

  assign en = !v[BL-1] || res.ready;
  assign q_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[BL-2:0], q_valid};
    end
  end

  // square root, one result bit per stage
  logic [TW-1:0] op_s [RW], rt_s [RW];
  logic signed [D1W-1:0] d1_s [RW];
  logic signed [D2W-1:0] d2_s [RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam logic [TW-1:0] ONE = TW'(1) << (2 * (RW - 1 - k));
    logic [TW-1:0] op_i, rt_i, sum;
    logic signed [D1W-1:0] d1_k;
    logic signed [D2W-1:0] d2_k;
    if (k == 0) begin : g_first
      assign op_i = {nsq_i, 32'b0};
      assign rt_i = '0;
      assign d1_k = d1_i;
      assign d2_k = d2_i;
    end else begin : g_next
      assign op_i = op_s[k-1];
      assign rt_i = rt_s[k-1];
      assign d1_k = d1_s[k-1];
      assign d2_k = d2_s[k-1];
    end
    assign sum = rt_i + ONE;
    always_ff @(posedge clk) begin
      if (en) begin
        if (op_i >= sum) begin
          op_s[k] <= op_i - sum;
          rt_s[k] <= (rt_i >> 1) + ONE;
        end else begin
          op_s[k] <= op_i;
          rt_s[k] <= rt_i >> 1;
        end
        d1_s[k] <= d1_k;
        d2_s[k] <= d2_k;
      end
    end
  end

  // sine term
  logic signed [RW+D1W:0] sp;
  logic signed [D2W-1:0] d2_m [NC2];

  dha_mul #(.AW(RW + 1), .BWID(D1W)) u_sin (
    .clk(clk), .en(en), .a($signed({1'b0, rt_s[RW-1][RW-1:0]})),
    .b(d1_s[RW-1]), .p(sp)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d2_m[0] <= d2_s[RW-1];
      for (int k = 1; k < NC2; k++) d2_m[k] <= d2_m[k-1];
    end
  end

  // magnitudes and signs
  logic signed [PW:0] s_ext, c_ext;
  logic [PW-1:0] smag1, cmag1;
  logic sneg1, cneg1, zr1;

  assign s_ext = (PW+1)'(sp);
  assign c_ext = (PW+1)'(d2_m[NC2-1]) <<< 16;

  always_ff @(posedge clk) begin
    if (en) begin
      smag1 <= PW'(s_ext < 0 ? -s_ext : s_ext);
      cmag1 <= PW'(c_ext < 0 ? -c_ext : c_ext);
      sneg1 <= s_ext < 0;
      cneg1 <= c_ext < 0;
      zr1 <= (s_ext == 0) && (c_ext == 0);
    end
  end

  // leading one search
  logic [NG*CH-1:0] mor2;
  logic [NG-1:0] gnz2;
  logic [PW-1:0] smag2, cmag2, smag3, cmag3;
  logic sneg2, cneg2, zr2, sneg3, cneg3, zr3;
  logic [TPW-1:0] top3, top_c;
  logic [NG*CH-1:0] mor_c;

  assign mor_c = (NG*CH)'(smag1 | cmag1);

  always_comb begin
    int gi;
    int bi;
    logic [CH-1:0] grp;
    gi = 0;
    bi = 0;
    for (int g = 0; g < NG; g++) if (gnz2[g]) gi = g;
    grp = mor2[gi*CH +: CH];
    for (int b = 0; b < CH; b++) if (grp[b]) bi = b;
    top_c = TPW'(gi * CH + bi);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mor2 <= mor_c;
      for (int g = 0; g < NG; g++) gnz2[g] <= |mor_c[g*CH +: CH];
      smag2 <= smag1;
      cmag2 <= cmag1;
      sneg2 <= sneg1;
      cneg2 <= cneg1;
      zr2 <= zr1;
      top3 <= top_c;
      smag3 <= smag2;
      cmag3 <= cmag2;
      sneg3 <= sneg2;
      cneg3 <= cneg2;
      zr3 <= zr2;
    end
  end

  // align both terms so the leading one sits at bit 29
  logic [TK-1:0] xs, ys, x4, y4;
  logic sneg4, cneg4, zr4;

  always_comb begin
    int t;
    logic [PW-1:0] cx, sy;
    t = int'(top3);
    if (t < TK - 1) begin
      cx = cmag3 << (TK - 1 - t);
      sy = smag3 << (TK - 1 - t);
    end else begin
      cx = cmag3 >> (t - (TK - 1));
      sy = smag3 >> (t - (TK - 1));
    end
    xs = cx[TK-1:0];
    ys = sy[TK-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x4 <= xs;
      y4 <= ys;
      sneg4 <= sneg3;
      cneg4 <= cneg3;
      zr4 <= zr3;
    end
  end

  // CORDIC vectoring
  logic signed [XW-1:0] cx_s [CORDIC_STEPS], cy_s [CORDIC_STEPS];
  logic signed [ZW-1:0] cz_s [CORDIC_STEPS];
  logic sn_s [CORDIC_STEPS], cn_s [CORDIC_STEPS], zr_s [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [XW-1:0] x_i, y_i, dx, dy;
    logic signed [ZW-1:0] z_i, ang;
    logic sn_i, cn_i, zr_i;
    if (i == 0) begin : g_first
      assign x_i = $signed({{(XW-TK){1'b0}}, x4});
      assign y_i = $signed({{(XW-TK){1'b0}}, y4});
      assign z_i = '0;
      assign sn_i = sneg4;
      assign cn_i = cneg4;
      assign zr_i = zr4;
    end else begin : g_next
      assign x_i = cx_s[i-1];
      assign y_i = cy_s[i-1];
      assign z_i = cz_s[i-1];
      assign sn_i = sn_s[i-1];
      assign cn_i = cn_s[i-1];
      assign zr_i = zr_s[i-1];
    end
    assign dx = y_i >>> i;
    assign dy = x_i >>> i;
    assign ang = $signed({{(ZW-30){1'b0}}, dha_pkg::ATAN_TAB[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_i >= 0) begin
          cx_s[i] <= x_i + dx;
          cy_s[i] <= y_i - dy;
          cz_s[i] <= z_i + ang;
        end else begin
          cx_s[i] <= x_i - dx;
          cy_s[i] <= y_i + dy;
          cz_s[i] <= z_i - ang;
        end
        sn_s[i] <= sn_i;
        cn_s[i] <= cn_i;
        zr_s[i] <= zr_i;
      end
    end
  end

  // quadrant, round, saturate
  logic signed [HW-1:0] th_a, th, qr, qs;
  logic signed [AW-1:0] angle_q;
  logic deg_q;

  always_comb begin
    th_a = cn_s[CORDIC_STEPS-1] ? dha_pkg::PI30 - HW'(cz_s[CORDIC_STEPS-1])
                                : HW'(cz_s[CORDIC_STEPS-1]);
    th = sn_s[CORDIC_STEPS-1] ? -th_a : th_a;
    qr = (th + HALF) >>> SH;
    if (qr > PIQ) qs = PIQ;
    else if (qr < -PIQ) qs = -PIQ;
    else qs = qr;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_q <= zr_s[CORDIC_STEPS-1] ? '0 : qs[AW-1:0];
      deg_q <= zr_s[CORDIC_STEPS-1];
    end
  end

  assign res.valid = v[BL-1];
  assign res.angle = angle_q;
  assign res.degenerate = deg_q;
endmodule
